@@ hw/rtl/per_source_token_bucket_policer_macros.svh @@
// Assertion macros shared by the policer top level.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PER_SOURCE_TOKEN_BUCKET_POLICER_MACROS_SVH
`define PER_SOURCE_TOKEN_BUCKET_POLICER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pstbp_pkg.sv @@
// Shared types and constants of the per-source token bucket policer.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pstbp_pkg;

    // Table depth; must be a power of two so the slot is the low address bits.
    localparam int NUM_BUCKETS_DEFAULT = 1024;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 48;
    localparam int TOKEN_W  = 16;
    localparam int RATE_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int ENTRY_W  = ADDR_W + TOKEN_W + TIME_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_PER_SECOND = 1'b1;

    localparam int MS_PER_SECOND = 1000;

    // Any refill of 2^17 or more saturates the bucket, so only the low
    // elapsed bits go through the multiplier and the divider.
    localparam int ELAPSED_LOW_W = 27;
    localparam int PRODUCT_W     = ELAPSED_LOW_W + RATE_W;
    localparam longint SAT_PRODUCT = longint'(MS_PER_SECOND) * 131072;
    localparam int PROD_DIV_W    = 27;

    // Division by 1000 is a shift by three followed by a multiply with the
    // rounded-up reciprocal of 125; it is exact for every dividend below 2^27.
    localparam int DIV_PRE_SHIFT = 3;
    localparam int RECIP_IN_W    = PROD_DIV_W - DIV_PRE_SHIFT;
    localparam int RECIP_W       = 25;
    localparam int RECIP_SHIFT   = 31;
    localparam logic [RECIP_W-1:0] RECIP_125 = 25'd17179870;
    localparam int RECIP_PROD_W  = RECIP_IN_W + RECIP_W;
    localparam int QUO_W         = 18;
    localparam int SUM_W         = QUO_W + 1;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic latch_rd;
        logic mul;
        logic divide;
        logic update;
        logic finish;
    } pstbp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cap_zero;
    } pstbp_status_t;

endpackage

@@ hw/rtl/pstbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the bucket table of the policer.
`timescale 1ns / 1ps

module pstbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pstbp_ctrl.sv @@
// Sequencing state machine of the policer: clearing pass, one item at a time.
// Depends on pstbp_pkg for the command and status structs.
`timescale 1ns / 1ps

module pstbp_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  pstbp_pkg::pstbp_status_t status,
    output pstbp_pkg::pstbp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_UPD,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.accept   = accept;
        cmd.latch_rd = (state_reg == S_READ);
        cmd.mul      = (state_reg == S_MUL);
        cmd.divide   = (state_reg == S_DIV);
        cmd.update   = (state_reg == S_UPD);
        cmd.finish   = (state_reg == S_FINISH) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    // With limiting off the result needs no table access.
                    state_next = status.cap_zero ? S_FINISH : S_READ;
                end
            end
            S_READ:    state_next = S_MUL;
            S_MUL:     state_next = S_DIV;
            S_DIV:     state_next = S_UPD;
            S_UPD:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/pstbp_datapath.sv @@
// Datapath of the policer: configuration, bucket RAM, refill multiply,
// division by 1000 and the token update. Depends on pstbp_pkg and pstbp_ram.
`timescale 1ns / 1ps

module pstbp_datapath #(
    parameter int NUM_BUCKETS = pstbp_pkg::NUM_BUCKETS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pstbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pstbp_pkg::CFG_W-1:0]         cfg_data,
    input  logic [pstbp_pkg::ADDR_W-1:0]        source_addr,
    input  logic [pstbp_pkg::TIME_W-1:0]        now_ms,
    output logic                                admit,
    input  pstbp_pkg::pstbp_cmd_t               cmd,
    output pstbp_pkg::pstbp_status_t            status
);

    localparam int SLOT_W = $clog2(NUM_BUCKETS);

    logic [pstbp_pkg::TOKEN_W-1:0]       cap_reg;
    logic [pstbp_pkg::RATE_W-1:0]        rate_reg;
    logic [SLOT_W-1:0]                   clear_cnt_reg;

    logic [pstbp_pkg::ADDR_W-1:0]        addr_reg;
    logic [pstbp_pkg::TIME_W-1:0]        now_reg;
    logic                                bypass_reg;

    logic                                hit_reg;
    logic [pstbp_pkg::TOKEN_W-1:0]       tokens_reg;
    logic [pstbp_pkg::TIME_W-1:0]        stamp_reg;
    logic [pstbp_pkg::ELAPSED_LOW_W-1:0] el_lo_reg;
    logic                                el_hi_nz_reg;

    logic [pstbp_pkg::PRODUCT_W-1:0]     product_reg;
    logic                                big_reg;
    logic [pstbp_pkg::QUO_W-1:0]         quo_reg;
    logic [pstbp_pkg::RECIP_PROD_W-1:0]  recip_prod;

    logic [pstbp_pkg::TOKEN_W-1:0]       new_tokens_reg, new_tokens_next;
    logic                                stamp_upd_reg, stamp_upd_next;
    logic                                admit_calc_reg, admit_calc_next;
    logic                                admit_reg;

    logic                                ram_we;
    logic [SLOT_W-1:0]                   ram_waddr;
    logic [pstbp_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [pstbp_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [pstbp_pkg::ADDR_W-1:0]        rd_tag;
    logic [pstbp_pkg::TOKEN_W-1:0]       rd_tokens;
    logic [pstbp_pkg::TIME_W-1:0]        rd_stamp;
    logic [pstbp_pkg::TIME_W-1:0]        elapsed;

    assign {rd_tag, rd_tokens, rd_stamp} = ram_rdata;
    assign elapsed = now_reg - rd_stamp;

    assign status.clear_last = (clear_cnt_reg == SLOT_W'(NUM_BUCKETS - 1));
    assign status.cap_zero   = (cap_reg == '0);

    // The clearing pass owns the write port until the table is zeroed.
    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.finish && !bypass_reg;
            ram_waddr = addr_reg[SLOT_W-1:0];
            ram_wdata = {addr_reg, new_tokens_reg, stamp_upd_reg ? now_reg : stamp_reg};
        end
    end

    pstbp_ram #(
        .WIDTH (pstbp_pkg::ENTRY_W),
        .DEPTH (NUM_BUCKETS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (source_addr[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Product divided by 1000: drop the factor of eight, then multiply by the
    // reciprocal of 125. Only products below the saturation point matter here.
    assign recip_prod =
        pstbp_pkg::RECIP_PROD_W'(product_reg[pstbp_pkg::PROD_DIV_W-1:pstbp_pkg::DIV_PRE_SHIFT])
        * pstbp_pkg::RECIP_PROD_W'(pstbp_pkg::RECIP_125);

    // Token update: claim on a tag miss, otherwise refill with saturation,
    // then take one token if there is one.
    always_comb
    begin
        logic                          refill_nz;
        logic [pstbp_pkg::SUM_W-1:0]   sum_wide;
        logic [pstbp_pkg::TOKEN_W-1:0] level;
        refill_nz = big_reg || (quo_reg != '0);
        sum_wide  = pstbp_pkg::SUM_W'(tokens_reg) + pstbp_pkg::SUM_W'(quo_reg);
        if (!hit_reg)
        begin
            level = cap_reg;
        end
        else if (refill_nz)
        begin
            if (big_reg || (sum_wide > pstbp_pkg::SUM_W'(cap_reg)))
            begin
                level = cap_reg;
            end
            else
            begin
                level = sum_wide[pstbp_pkg::TOKEN_W-1:0];
            end
        end
        else
        begin
            // A level above a lowered capacity is kept when nothing is added.
            level = tokens_reg;
        end
        admit_calc_next = (level != '0);
        new_tokens_next = (level != '0) ? level - 1'b1 : level;
        stamp_upd_next  = !hit_reg || refill_nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= '0;
            rate_reg      <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pstbp_pkg::REG_BUCKET_CAPACITY:   cap_reg  <= cfg_data;
                    pstbp_pkg::REG_REFILL_PER_SECOND: rate_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_wr)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg   <= source_addr;
            now_reg    <= now_ms;
            bypass_reg <= (cap_reg == '0);
        end
        if (cmd.latch_rd)
        begin
            hit_reg      <= (rd_tag == addr_reg);
            tokens_reg   <= rd_tokens;
            stamp_reg    <= rd_stamp;
            el_lo_reg    <= elapsed[pstbp_pkg::ELAPSED_LOW_W-1:0];
            el_hi_nz_reg <= (elapsed[pstbp_pkg::TIME_W-1:pstbp_pkg::ELAPSED_LOW_W] != '0);
        end
        if (cmd.mul)
        begin
            product_reg <= pstbp_pkg::PRODUCT_W'(el_lo_reg) * pstbp_pkg::PRODUCT_W'(rate_reg);
        end
        if (cmd.divide)
        begin
            big_reg <= (el_hi_nz_reg && (rate_reg != '0))
                       || (product_reg >= pstbp_pkg::PRODUCT_W'(pstbp_pkg::SAT_PRODUCT));
            quo_reg <= recip_prod[pstbp_pkg::RECIP_SHIFT +: pstbp_pkg::QUO_W];
        end
        if (cmd.update)
        begin
            new_tokens_reg <= new_tokens_next;
            stamp_upd_reg  <= stamp_upd_next;
            admit_calc_reg <= admit_calc_next;
        end
        if (cmd.finish)
        begin
            admit_reg <= bypass_reg ? 1'b1 : admit_calc_reg;
        end
    end

    assign admit = admit_reg;

endmodule

@@ hw/rtl/per_source_token_bucket_policer.sv @@
// Top level of the per-source token bucket policer.
// Depends on pstbp_pkg, pstbp_ctrl, pstbp_datapath and the assertion macros.
//
//   Channel   Handshake                Payload
//   config    cfg_we                   cfg_index, cfg_data
//   request   in_valid / in_stall      source_addr, now_ms
//   result    out_valid / out_stall    admit
//
// With limiting on a request goes from transfer to result through table
// read, rate multiply, reciprocal multiply for the division by 1000, token
// update and write-back; with a zero capacity it skips the table and goes
// straight to the result. A new request can follow the cycle after its result
// is loaded. After reset a clearing pass zeroes every table entry with in_stall
// high. A stalled result holds the block in its write-back cycle; NUM_BUCKETS must be a power of two.
`timescale 1ns / 1ps
`include "per_source_token_bucket_policer_macros.svh"

module per_source_token_bucket_policer #(
    parameter int NUM_BUCKETS = pstbp_pkg::NUM_BUCKETS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pstbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pstbp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pstbp_pkg::ADDR_W-1:0]     source_addr,
    input  logic [pstbp_pkg::TIME_W-1:0]     now_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             admit
);

    pstbp_pkg::pstbp_cmd_t    cmd;
    pstbp_pkg::pstbp_status_t status;
    logic                     work_cmd;

    pstbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pstbp_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .source_addr (source_addr),
        .now_ms      (now_ms),
        .admit       (admit),
        .cmd         (cmd),
        .status      (status)
    );

    assign work_cmd = cmd.accept || cmd.latch_rd || cmd.mul || cmd.divide
                      || cmd.update || cmd.finish;

    // Only one item is in flight: a transfer closes the request side.
    `PSTBP_ASSERT_NEXT(a_single_item, clk, rst_n, in_valid && !in_stall, in_stall, "overlap")
    // The result register is loaded only when the previous result has gone.
    `PSTBP_ASSERT_NOW(a_finish_free, clk, rst_n, cmd.finish, !out_valid || !out_stall, "overwrite")
    // The divide cycle is followed by the token update.
    `PSTBP_ASSERT_NEXT(a_div_then_upd, clk, rst_n, cmd.divide, cmd.update, "divide sequence broken")
    // The clearing pass never overlaps item processing.
    `PSTBP_ASSERT_NOW(a_clear_alone, clk, rst_n, cmd.clear_wr, !work_cmd, "clear overlap")

endmodule
